// ===== src/tvbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Transformed vertex bounding box: shared definitions
// Widths, register indexes, reset values, control structs and the
// saturation helper used by the transform lanes and the top level.
// ----------------------------------------------------------------------------
package tvbb_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int COEFF_FRAC_BITS = 12;
    localparam int LANE_BITS       = 16;
    localparam int ROW_WIDTH       = 4 * LANE_BITS;
    localparam int NUM_AXES        = 3;
    localparam int CFG_INDEX_WIDTH = 2;

    // One coefficient times one coordinate.
    localparam int PROD_WIDTH  = COORD_WIDTH + LANE_BITS;
    // Translation aligned to the product's binary point.
    localparam int TRANS_WIDTH = LANE_BITS + COEFF_FRAC_BITS;
    // Three products, the translation and the rounding term need three guard bits.
    localparam int ACC_WIDTH   = ((PROD_WIDTH > TRANS_WIDTH) ? PROD_WIDTH : TRANS_WIDTH) + 3;
    // Accumulator after dropping the coefficient fraction bits.
    localparam int SHIFT_WIDTH = ACC_WIDTH - COEFF_FRAC_BITS;

    typedef logic signed [COORD_WIDTH-1:0]     t_coord;
    typedef logic [ROW_WIDTH-1:0]              t_row;
    typedef logic [CFG_INDEX_WIDTH-1:0]        t_cfg_index;
    typedef logic [ROW_WIDTH-1:0]              t_cfg_data;

    // Register indexes of the configuration port.
    localparam t_cfg_index REG_ROW_X = t_cfg_index'(0);
    localparam t_cfg_index REG_ROW_Y = t_cfg_index'(1);
    localparam t_cfg_index REG_ROW_Z = t_cfg_index'(2);

    // Identity matrix: coefficient 1.0 on the diagonal, no translation.
    localparam t_row ROW_X_RESET = 64'h0000_0000_0000_1000;
    localparam t_row ROW_Y_RESET = 64'h0000_0000_1000_0000;
    localparam t_row ROW_Z_RESET = 64'h0000_1000_0000_0000;

    // Half an output LSB, for round half up.
    localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
        ACC_WIDTH'(1) <<< (COEFF_FRAC_BITS - 1);

    // Load enables of the two transform stages.
    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } t_xform_ctl;

    // Control of the running minimum and maximum.
    typedef struct packed {
        logic take;
        logic start;
    } t_acc_ctl;

    // Clamp a shifted accumulator to the signed coordinate range.
    function automatic t_coord saturate(input logic signed [SHIFT_WIDTH-1:0] v);
        logic signed [SHIFT_WIDTH-1:0] hi;
        logic signed [SHIFT_WIDTH-1:0] lo;
        hi = {{(SHIFT_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
        lo = {{(SHIFT_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
        if (v > hi) begin
            return hi[COORD_WIDTH-1:0];
        end else if (v < lo) begin
            return lo[COORD_WIDTH-1:0];
        end else begin
            return v[COORD_WIDTH-1:0];
        end
    endfunction

endpackage

// ===== src/tvbb_axis_xform.sv =====
// ----------------------------------------------------------------------------
// Transform lane for one axis
// Two stages: the three coefficient products, then the sum with the
// translation, round half up and saturation to the coordinate range.
// ----------------------------------------------------------------------------
module tvbb_axis_xform (
    input  logic                 i_clk,
    input  tvbb_pkg::t_xform_ctl i_ctl,
    input  tvbb_pkg::t_row       i_row,
    input  tvbb_pkg::t_coord     i_x,
    input  tvbb_pkg::t_coord     i_y,
    input  tvbb_pkg::t_coord     i_z,
    output tvbb_pkg::t_coord     o_coord
);
    import tvbb_pkg::*;

    logic signed [LANE_BITS-1:0]   c0;
    logic signed [LANE_BITS-1:0]   c1;
    logic signed [LANE_BITS-1:0]   c2;
    logic signed [LANE_BITS-1:0]   trans;

    logic signed [PROD_WIDTH-1:0]  r_p0;
    logic signed [PROD_WIDTH-1:0]  r_p1;
    logic signed [PROD_WIDTH-1:0]  r_p2;
    logic signed [LANE_BITS-1:0]   r_trans;

    logic signed [ACC_WIDTH-1:0]   n_acc;
    logic signed [SHIFT_WIDTH-1:0] n_shift;
    t_coord                        r_coord;

    assign c0    = i_row[LANE_BITS-1:0];
    assign c1    = i_row[2*LANE_BITS-1:LANE_BITS];
    assign c2    = i_row[3*LANE_BITS-1:2*LANE_BITS];
    assign trans = i_row[4*LANE_BITS-1:3*LANE_BITS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_p0    <= PROD_WIDTH'(c0) * PROD_WIDTH'(i_x);
            r_p1    <= PROD_WIDTH'(c1) * PROD_WIDTH'(i_y);
            r_p2    <= PROD_WIDTH'(c2) * PROD_WIDTH'(i_z);
            r_trans <= trans;
        end
    end

    // The accumulator carries 8 + COEFF_FRAC_BITS fraction bits; dropping the
    // low bits after adding half an LSB gives the floor-based rounding.
    always_comb begin
        n_acc = ACC_WIDTH'(r_p0) + ACC_WIDTH'(r_p1) + ACC_WIDTH'(r_p2)
              + (ACC_WIDTH'(r_trans) <<< COEFF_FRAC_BITS) + ROUND_HALF;
        n_shift = n_acc[ACC_WIDTH-1:COEFF_FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sum) begin
            r_coord <= saturate(n_shift);
        end
    end

    assign o_coord = r_coord;

endmodule

// ===== src/tvbb_axis_acc.sv =====
// ----------------------------------------------------------------------------
// Running extent for one axis
// Holds the smallest and largest coordinate seen in the current list and
// presents the values that include the coordinate now being taken.
// ----------------------------------------------------------------------------
module tvbb_axis_acc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tvbb_pkg::t_acc_ctl i_ctl,
    input  tvbb_pkg::t_coord   i_coord,
    output tvbb_pkg::t_coord   o_next_min,
    output tvbb_pkg::t_coord   o_next_max
);
    import tvbb_pkg::*;

    t_coord r_min;
    t_coord r_max;
    t_coord n_min;
    t_coord n_max;

    // The first vertex of a list replaces the extent outright.
    always_comb begin
        n_min = (i_ctl.start || (i_coord < r_min)) ? i_coord : r_min;
        n_max = (i_ctl.start || (i_coord > r_max)) ? i_coord : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_ctl.take) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_next_min = n_min;
    assign o_next_max = n_max;

endmodule

// ===== src/transformed_vertex_bounding_box.sv =====
// ----------------------------------------------------------------------------
// Transformed vertex bounding box
// Transforms a stream of Q8.8 vertices by a 3x4 affine matrix and reports
// the axis-aligned box of each vertex list.
// ----------------------------------------------------------------------------
// Usage:
// Vertices arrive on the input channel (i_valid / o_ready), one per transfer,
// with i_last_vertex marking the final vertex of a list. Each vertex is
// multiplied by the matrix held in three row registers, which the user must
// write through the configuration port (i_cfg_we, i_cfg_index, i_cfg_data)
// only while the block is idle; the block does not enforce it. A write to
// an index past the last row is ignored. One box leaves on the output channel
// (o_valid / i_ready) for each list, after the last vertex passes the input
// register, product stage, sum and saturate stage, then the box register.
// Throughput is one vertex per cycle unless a last vertex waits on the
// output. The pipeline moves as a whole except that stages holding nothing
// fill in, and vertices that are not last never wait on the output. While
// a box sits unclaimed in the output register, vertices keep flowing; only
// the next last vertex waits for it. Reset loads the identity matrix, empties
// the pipeline and the output, and makes the next vertex start a new list.
// ----------------------------------------------------------------------------
module transformed_vertex_bounding_box (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration port
    input  logic                 i_cfg_we,
    input  tvbb_pkg::t_cfg_index i_cfg_index,
    input  tvbb_pkg::t_cfg_data  i_cfg_data,
    // Vertex input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tvbb_pkg::t_coord     i_vertex_x,
    input  tvbb_pkg::t_coord     i_vertex_y,
    input  tvbb_pkg::t_coord     i_vertex_z,
    input  logic                 i_last_vertex,
    // Box output channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output tvbb_pkg::t_coord     o_box_min_x,
    output tvbb_pkg::t_coord     o_box_max_x,
    output tvbb_pkg::t_coord     o_box_min_y,
    output tvbb_pkg::t_coord     o_box_max_y,
    output tvbb_pkg::t_coord     o_box_min_z,
    output tvbb_pkg::t_coord     o_box_max_z
);
    import tvbb_pkg::*;

    // Matrix rows, indexed by axis.
    t_row       r_row [NUM_AXES];

    // Input register stage.
    logic       r_a_v;
    t_coord     r_a_x;
    t_coord     r_a_y;
    t_coord     r_a_z;
    logic       r_a_last;

    // Product stage and sum stage only carry their flags here; the
    // arithmetic payload lives in the transform lanes.
    logic       r_b_v;
    logic       r_b_last;
    logic       r_c_v;
    logic       r_c_last;

    logic       r_list_start;

    // Output register.
    logic       r_out_v;
    t_coord     r_out_min [NUM_AXES];
    t_coord     r_out_max [NUM_AXES];

    logic       out_free;
    logic       take_c;
    logic       adv_a;
    logic       adv_b;
    logic       adv_c;
    t_xform_ctl xform_ctl;
    t_acc_ctl   acc_ctl;

    t_coord     c_coord [NUM_AXES];
    t_coord     n_min   [NUM_AXES];
    t_coord     n_max   [NUM_AXES];

    // A stage may load when it is empty or its content moves on. The sum
    // stage hands its vertex to the extent logic at once, unless the vertex
    // closes a list and the output register is still occupied.
    always_comb begin
        out_free            = !r_out_v || i_ready;
        take_c              = r_c_v && (!r_c_last || out_free);
        adv_c               = !r_c_v || take_c;
        adv_b               = !r_b_v || adv_c;
        adv_a               = !r_a_v || adv_b;
        xform_ctl.load_prod = adv_b && r_a_v;
        xform_ctl.load_sum  = adv_c && r_b_v;
        acc_ctl.take        = take_c;
        acc_ctl.start       = r_list_start;
    end

    assign o_ready = adv_a;

    // Control state and the matrix registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]     <= ROW_X_RESET;
            r_row[1]     <= ROW_Y_RESET;
            r_row[2]     <= ROW_Z_RESET;
            r_a_v        <= 1'b0;
            r_b_v        <= 1'b0;
            r_c_v        <= 1'b0;
            r_list_start <= 1'b1;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ROW_X: r_row[0] <= i_cfg_data;
                    REG_ROW_Y: r_row[1] <= i_cfg_data;
                    REG_ROW_Z: r_row[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (adv_a) begin
                r_a_v <= i_valid;
            end
            if (adv_b) begin
                r_b_v <= r_a_v;
            end
            if (adv_c) begin
                r_c_v <= r_b_v;
            end
            // A last vertex makes the following vertex open a new list.
            if (take_c) begin
                r_list_start <= r_c_last;
            end
            if (take_c && r_c_last) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && adv_a) begin
            r_a_x    <= i_vertex_x;
            r_a_y    <= i_vertex_y;
            r_a_z    <= i_vertex_z;
            r_a_last <= i_last_vertex;
        end
        if (xform_ctl.load_prod) begin
            r_b_last <= r_a_last;
        end
        if (xform_ctl.load_sum) begin
            r_c_last <= r_b_last;
        end
    end

    // One transform lane and one running extent per axis.
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        tvbb_axis_xform u_xform (
            .i_clk   (i_clk),
            .i_ctl   (xform_ctl),
            .i_row   (r_row[a]),
            .i_x     (r_a_x),
            .i_y     (r_a_y),
            .i_z     (r_a_z),
            .o_coord (c_coord[a])
        );

        tvbb_axis_acc u_acc (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (acc_ctl),
            .i_coord    (c_coord[a]),
            .o_next_min (n_min[a]),
            .o_next_max (n_max[a])
        );

        // The box includes the closing vertex itself.
        always_ff @(posedge i_clk) begin
            if (take_c && r_c_last) begin
                r_out_min[a] <= n_min[a];
                r_out_max[a] <= n_max[a];
            end
        end
    end

    assign o_valid     = r_out_v;
    assign o_box_min_x = r_out_min[0];
    assign o_box_max_x = r_out_max[0];
    assign o_box_min_y = r_out_min[1];
    assign o_box_max_y = r_out_max[1];
    assign o_box_min_z = r_out_min[2];
    assign o_box_max_z = r_out_max[2];

endmodule
